### rtl/sku_pkg.sv
package sku_pkg;

    localparam int SKU_MAX_SAMPLES = 16;
    localparam int SKU_KEY_W       = 32;
    localparam int SKU_CLIP_W      = 8;
    localparam int SKU_ALPHA_W     = 16;
    localparam int SKU_CFG_IDX_W   = 2;
    localparam int SKU_CFG_DATA_W  = 32;

    // serial divider widths: dividend stream, divisor, partial remainder, step count
    localparam int SKU_DVD_W = 33;
    localparam int SKU_DEN_W = 36;
    localparam int SKU_REM_W = 37;
    localparam int SKU_STP_W = 6;
    localparam int SKU_MOD_STEPS  = 33;
    localparam int SKU_FRAC_STEPS = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    typedef enum logic [SKU_CFG_IDX_W-1:0] {
        CFG_RANGE_MIN   = 2'd0,
        CFG_RANGE_MAX   = 2'd1,
        CFG_WRAP_ENABLE = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_SHF_RD,
        ST_SHF_CMP,
        ST_COND,
        ST_MOD,
        ST_QRY_RD,
        ST_QRY_CMP,
        ST_FRAC,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                          op;
        logic signed [SKU_KEY_W-1:0]  position;
        logic [SKU_CLIP_W-1:0]        clip_id;
    } t_in_item;

    typedef struct packed {
        logic                    pair_valid;
        logic [SKU_CLIP_W-1:0]   first_clip;
        logic [SKU_CLIP_W-1:0]   second_clip;
        logic [SKU_ALPHA_W-1:0]  blend_alpha;
        logic                    insert_rejected;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic [SKU_STP_W-1:0]  steps;
    } t_div_ctl;

    typedef struct packed {
        logic                    done;
        logic [SKU_REM_W-1:0]    rem;
        logic [SKU_ALPHA_W-1:0]  quo;
    } t_div_res;

endpackage

### rtl/sku_in_if.sv
interface sku_in_if;
    import sku_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/sku_out_if.sv
interface sku_out_if;
    import sku_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/sku_ram.sv
module sku_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry, read one registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sku_serdiv.sv
module sku_serdiv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sku_pkg::t_div_ctl               i_ctl,
    input  logic [sku_pkg::SKU_REM_W-1:0]   i_rem_init,
    input  logic [sku_pkg::SKU_DVD_W-1:0]   i_dividend,
    input  logic [sku_pkg::SKU_DEN_W-1:0]   i_divisor,
    output sku_pkg::t_div_res               o_res
);
    import sku_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [SKU_STP_W-1:0]  r_cnt;
    logic [SKU_REM_W-1:0]  r_rem;
    logic [SKU_DVD_W-1:0]  r_dvd;
    logic [SKU_ALPHA_W-1:0] r_quo;
    logic [SKU_DEN_W-1:0]  r_den;

    logic [SKU_REM_W-1:0]  w_trial;
    logic                  w_ge;

    // shift in one dividend bit and try one subtraction
    assign w_trial = {r_rem[SKU_REM_W-2:0], r_dvd[SKU_DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - SKU_STP_W'(1);
                if (r_cnt == SKU_STP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_rem_init;
            r_dvd <= i_dividend;
            r_den <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            r_dvd <= {r_dvd[SKU_DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[SKU_ALPHA_W-2:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.rem  = r_rem;
    assign o_res.quo  = r_quo;

endmodule

### rtl/sorted_key_blend_lookup.sv
// Insert: compares entries in order for an equal key, then moves each larger entry up by one
// and writes the new key; a replace stops at its match, a reject compares all n entries.
// Query: conditions the position (a modulo division when it wraps), searches entries in order,
// then bounds or divides the fraction; an empty table skips to the result. One bit-serial divider.
// Throughput: one item at a time; the next beat is taken once the result reaches the output.
// Reset: synchronous active low; clears count, range, wrap flag and control, not the table.
module sorted_key_blend_lookup #(
    parameter int MAX_SAMPLES = sku_pkg::SKU_MAX_SAMPLES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sku_in_if.sink                              i_in,
    sku_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [sku_pkg::SKU_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sku_pkg::SKU_CFG_DATA_W-1:0]  i_cfg_data
);
    import sku_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int EW = SKU_KEY_W + SKU_CLIP_W;

    t_state r_state, n_state;

    logic signed [SKU_KEY_W-1:0] r_min, r_max;
    logic                        r_wrap;

    t_op                          r_op, n_op;
    logic signed [SKU_KEY_W-1:0]  r_pos, n_pos;
    logic [SKU_CLIP_W-1:0]        r_clip, n_clip;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                r_idx, n_idx;
    logic signed [SKU_KEY_W-1:0]  r_v, n_v;
    logic                         r_below, n_below;
    logic signed [SKU_KEY_W-1:0]  r_prev_key, n_prev_key;
    logic [SKU_CLIP_W-1:0]        r_prev_clip, n_prev_clip;
    logic signed [SKU_KEY_W-1:0]  r_first_key, n_first_key;
    logic [SKU_CLIP_W-1:0]        r_first_clip, n_first_clip;
    logic signed [SKU_DEN_W-1:0]  r_num, n_num;
    logic signed [SKU_DEN_W-1:0]  r_den, n_den;
    t_out_item                    r_res, n_res;
    t_out_item                    r_out;
    logic                         r_out_valid;

    // table memory
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata;

    // divider
    t_div_ctl              w_div_ctl;
    t_div_res              w_div_res;
    logic [SKU_REM_W-1:0]  w_div_init;
    logic [SKU_DVD_W-1:0]  w_div_dvd;
    logic [SKU_DEN_W-1:0]  w_div_den;

    logic signed [SKU_KEY_W-1:0]  w_rkey;
    logic [SKU_CLIP_W-1:0]        w_rclip;
    logic signed [SKU_KEY_W-1:0]  w_fkey;
    logic [SKU_CLIP_W-1:0]        w_fclip;
    logic signed [SKU_DVD_W-1:0]  w_lo, w_hi, w_pv, w_span;
    logic signed [SKU_DVD_W:0]    w_rem34;
    logic                         w_out_free;
    logic                         w_last;

    sku_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sku_serdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_rem_init (w_div_init),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_den),
        .o_res      (w_div_res)
    );

    assign w_rkey  = signed'(w_rdata[EW-1:SKU_CLIP_W]);
    assign w_rclip = w_rdata[SKU_CLIP_W-1:0];
    assign w_fkey  = (r_idx == '0) ? w_rkey : r_first_key;
    assign w_fclip = (r_idx == '0) ? w_rclip : r_first_clip;
    assign w_lo    = SKU_DVD_W'(r_min);
    assign w_hi    = SKU_DVD_W'(r_max);
    assign w_pv    = SKU_DVD_W'(r_pos);
    assign w_span  = w_hi - w_lo;
    assign w_rem34 = signed'({1'b0, w_div_res.rem[SKU_DVD_W-1:0]});
    assign w_last  = ((r_idx + CW'(1)) == r_cnt);

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_max  <= '0;
            r_wrap <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RANGE_MIN:   r_min  <= signed'(i_cfg_data[SKU_KEY_W-1:0]);
                CFG_RANGE_MAX:   r_max  <= signed'(i_cfg_data[SKU_KEY_W-1:0]);
                CFG_WRAP_ENABLE: r_wrap <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_pos        <= n_pos;
        r_clip       <= n_clip;
        r_idx        <= n_idx;
        r_v          <= n_v;
        r_below      <= n_below;
        r_prev_key   <= n_prev_key;
        r_prev_clip  <= n_prev_clip;
        r_first_key  <= n_first_key;
        r_first_clip <= n_first_clip;
        r_num        <= n_num;
        r_den        <= n_den;
        r_res        <= n_res;
        if (r_state == ST_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_pos        = r_pos;
        n_clip       = r_clip;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_v          = r_v;
        n_below      = r_below;
        n_prev_key   = r_prev_key;
        n_prev_clip  = r_prev_clip;
        n_first_key  = r_first_key;
        n_first_clip = r_first_clip;
        n_num        = r_num;
        n_den        = r_den;
        n_res        = r_res;
        w_we         = 1'b0;
        w_waddr      = r_idx[AW-1:0];
        w_wdata      = {r_pos, r_clip};
        w_raddr      = r_idx[AW-1:0];
        w_div_ctl    = '0;
        w_div_init   = '0;
        w_div_dvd    = '0;
        w_div_den    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_op   = i_in.data.op;
                    n_pos  = i_in.data.position;
                    n_clip = i_in.data.clip_id;
                    n_idx  = '0;
                    n_res  = '0;
                    if (i_in.data.op == OP_INSERT) begin
                        n_state = (r_cnt == '0) ? ST_SHF_RD : ST_INS_RD;
                    end else begin
                        n_state = (r_cnt == '0) ? ST_DONE : ST_COND;
                    end
                end
            end

            // look for an equal key
            ST_INS_RD: begin
                n_state = ST_INS_CMP;
            end

            ST_INS_CMP: begin
                if (w_rkey == r_pos) begin
                    w_we    = 1'b1;
                    n_state = ST_DONE;
                end else if (w_last) begin
                    if (r_cnt == CW'(MAX_SAMPLES)) begin
                        n_res.insert_rejected = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_cnt;
                        n_state = ST_SHF_RD;
                    end
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_INS_RD;
                end
            end

            // move larger entries up by one, then drop the new key in
            ST_SHF_RD: begin
                w_raddr = AW'(r_idx - CW'(1));
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SHF_CMP;
                end
            end

            ST_SHF_CMP: begin
                w_we = 1'b1;
                if (w_rkey > r_pos) begin
                    w_wdata = w_rdata;
                    n_idx   = r_idx - CW'(1);
                    n_state = ST_SHF_RD;
                end else begin
                    n_cnt   = r_cnt + CW'(1);
                    n_state = ST_DONE;
                end
            end

            // condition the query position onto the axis
            ST_COND: begin
                n_idx   = '0;
                n_v     = r_pos;
                n_state = ST_QRY_RD;
                if (r_max == r_min) begin
                    n_v = r_max;
                end else if (r_wrap) begin
                    if (w_span > 0 && (r_pos < r_min || r_pos >= r_max)) begin
                        n_below          = (r_pos < r_min);
                        w_div_ctl.start  = 1'b1;
                        w_div_ctl.steps  = SKU_STP_W'(SKU_MOD_STEPS);
                        w_div_dvd        = (r_pos < r_min) ? unsigned'(w_lo - w_pv)
                                                           : unsigned'(w_pv - w_hi);
                        w_div_den        = SKU_DEN_W'(unsigned'(w_span));
                        n_state          = ST_MOD;
                    end
                end else if (r_pos < r_min) begin
                    n_v = r_min;
                end else if (r_pos > r_max) begin
                    n_v = r_max;
                end
            end

            ST_MOD: begin
                if (w_div_res.done) begin
                    n_v = r_below ? SKU_KEY_W'(SKU_DVD_W'(r_max) - w_rem34)
                                  : SKU_KEY_W'(SKU_DVD_W'(r_min) + w_rem34);
                    n_state = ST_QRY_RD;
                end
            end

            // search for the first key at or above the position
            ST_QRY_RD: begin
                n_state = ST_QRY_CMP;
            end

            ST_QRY_CMP: begin
                if (r_idx == '0) begin
                    n_first_key  = w_rkey;
                    n_first_clip = w_rclip;
                end
                n_res.pair_valid = 1'b1;
                if (w_rkey >= r_v) begin
                    if (r_idx == '0 || w_rkey == r_v) begin
                        n_res.first_clip  = w_rclip;
                        n_res.second_clip = w_rclip;
                        n_state = ST_DONE;
                    end else begin
                        n_res.first_clip  = r_prev_clip;
                        n_res.second_clip = w_rclip;
                        n_num   = SKU_DEN_W'(r_v) - SKU_DEN_W'(r_prev_key);
                        n_den   = SKU_DEN_W'(w_rkey) - SKU_DEN_W'(r_prev_key);
                        n_state = ST_FRAC;
                    end
                end else if (w_last) begin
                    n_res.first_clip = w_rclip;
                    if (r_wrap && r_max > r_min) begin
                        n_res.second_clip = w_fclip;
                        n_num   = SKU_DEN_W'(r_v) - SKU_DEN_W'(w_rkey);
                        n_den   = SKU_DEN_W'(r_max) + SKU_DEN_W'(w_fkey)
                                - SKU_DEN_W'(r_min) - SKU_DEN_W'(w_rkey);
                        n_state = ST_FRAC;
                    end else begin
                        n_res.second_clip = w_rclip;
                        n_state = ST_DONE;
                    end
                end else begin
                    n_prev_key  = w_rkey;
                    n_prev_clip = w_rclip;
                    n_idx       = r_idx + CW'(1);
                    n_state     = ST_QRY_RD;
                end
            end

            // bound the fraction, else divide it bit by bit
            ST_FRAC: begin
                if (r_num <= 0 || r_den <= 0) begin
                    n_state = ST_DONE;
                end else if (r_num >= r_den) begin
                    n_res.blend_alpha = '1;
                    n_state = ST_DONE;
                end else begin
                    w_div_ctl.start = 1'b1;
                    w_div_ctl.steps = SKU_STP_W'(SKU_FRAC_STEPS);
                    w_div_init      = SKU_REM_W'(unsigned'(r_num));
                    w_div_den       = unsigned'(r_den);
                    n_state         = ST_DIV;
                end
            end

            ST_DIV: begin
                if (w_div_res.done) begin
                    n_res.blend_alpha = w_div_res.quo;
                    n_state = ST_DONE;
                end
            end

            // hand the result to the output register
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule
